/* rtl/olst_pkg.sv */
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and codes for the ordered list store: request actions, result
// status codes, sequencer states and the control word fanned out to the cells.
// ----------------------------------------------------------------------------
package olst_pkg;

   localparam int POS_W = 8;
   localparam int VAL_W = 32;
   localparam int LEN_W = 8;

   typedef enum logic [1:0] {
      ACT_GET    = 2'd0,
      ACT_LOCATE = 2'd1,
      ACT_INSERT = 2'd2,
      ACT_DELETE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Control word broadcast to every cell.
   typedef struct packed {
      logic locate;     // search for the key instead of selecting by position
      logic insert_en;  // shift up from the position and write the key
      logic delete_en;  // shift down from the position
   } cell_ctl_type;

endpackage

/* rtl/olst_cell.sv */
// ----------------------------------------------------------------------------
// olst_cell
// One list slot. Holds one entry, shifts with its neighbors on insert and
// delete, and forwards one registered stage of the search wave toward cell 0.
// ----------------------------------------------------------------------------
module olst_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 8,
   parameter int XW    = 8
) (
   input  logic                         clock,
   input  olst_pkg::cell_ctl_type       ctl,
   input  logic [XW-1:0]                pos_x,
   input  logic [XW-1:0]                count_x,
   input  logic [olst_pkg::VAL_W-1:0]   key,
   input  logic [olst_pkg::VAL_W-1:0]   left_value,
   input  logic [olst_pkg::VAL_W-1:0]   right_value,
   input  logic [olst_pkg::VAL_W-1:0]   carry_in_value,
   input  logic [CW-1:0]                carry_in_pos,
   output logic [olst_pkg::VAL_W-1:0]   value,
   output logic [olst_pkg::VAL_W-1:0]   carry_out_value,
   output logic [CW-1:0]                carry_out_pos
);

   localparam logic [XW-1:0] IDX1   = XW'(INDEX + 1);
   localparam logic [CW-1:0] IDX1_C = CW'(INDEX + 1);

   logic [olst_pkg::VAL_W-1:0] value_ff, value_in;
   logic [olst_pkg::VAL_W-1:0] carry_value_ff, carry_value_in;
   logic [CW-1:0]              carry_pos_ff, carry_pos_in;
   logic                       live;
   logic                       hit;

   always_comb begin
      live = (IDX1 <= count_x);
      // locate takes the lowest live match; get and delete take the addressed slot
      hit  = ctl.locate ? (live && (value_ff == key)) : (IDX1 == pos_x);

      carry_value_in = hit ? value_ff : carry_in_value;
      carry_pos_in   = hit ? IDX1_C : carry_in_pos;

      priority if (ctl.insert_en && (IDX1 == pos_x)) begin
         value_in = key;
      end else if (ctl.insert_en && (IDX1 > pos_x)) begin
         value_in = left_value;
      end else if (ctl.delete_en && (IDX1 >= pos_x)) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      carry_value_ff <= carry_value_in;
      carry_pos_ff   <= carry_pos_in;
   end

   assign value           = value_ff;
   assign carry_out_value = carry_value_ff;
   assign carry_out_pos   = carry_pos_ff;

endmodule

/* rtl/ordered_list_store.sv */
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered list of signed 32-bit values kept in a chain of cells, addressed by
// 1-based position, with get, locate, insert and delete requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid high and cannot be
// held off. Insert skips the lookup and goes from idle straight to finish.
// Get, locate and delete first wait for the lookup, a registered wave that
// moves one cell per cycle from the top of the cell chain down to cell 0,
// after which any shift is applied to all cells at once. busy drops as
// the result is driven, so the next request may be taken in that cycle.
module ordered_list_store #(
   parameter int CAPACITY = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [olst_pkg::POS_W-1:0]         req_position,
   input  logic signed [olst_pkg::VAL_W-1:0]  req_item_value,
   output logic                               rsp_valid,
   output logic signed [olst_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [olst_pkg::LEN_W-1:0]         rsp_found_position,
   output logic [1:0]                         rsp_status,
   output logic [olst_pkg::LEN_W-1:0]         rsp_list_length
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int XW  = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;
   localparam int SCW = $clog2(CAPACITY);
   localparam logic [SCW-1:0] SCAN_LAST = SCW'(CAPACITY - 1);
   localparam logic [CW-1:0]  CAP_C     = CW'(CAPACITY);

   olst_pkg::state_type        state_ff, state_in;
   logic [SCW-1:0]             scan_ff, scan_in;
   logic [CW-1:0]              count_ff, count_in;
   olst_pkg::action_type       action_ff, action_in;
   logic [olst_pkg::POS_W-1:0] position_ff, position_in;
   logic [olst_pkg::VAL_W-1:0] key_ff, key_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [olst_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [olst_pkg::LEN_W-1:0] rsp_found_ff, rsp_found_in;
   olst_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [olst_pkg::LEN_W-1:0] rsp_length_ff, rsp_length_in;

   olst_pkg::cell_ctl_type     ctl;
   logic [XW-1:0]              pos_x;
   logic [XW-1:0]              count_x;
   logic                       accept;
   logic                       rd_bad;
   logic                       ins_bad;

   logic [olst_pkg::VAL_W-1:0] cell_value [CAPACITY];
   logic [olst_pkg::VAL_W-1:0] carry_value [CAPACITY+1];
   logic [CW-1:0]              carry_pos [CAPACITY+1];

   assign carry_value[CAPACITY] = '0;
   assign carry_pos[CAPACITY]   = '0;

   assign busy    = (state_ff != olst_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign pos_x   = XW'(position_ff);
   assign count_x = XW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      action_in     = action_ff;
      position_in   = position_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;

      ctl.locate    = (action_ff == olst_pkg::ACT_LOCATE);
      ctl.insert_en = 1'b0;
      ctl.delete_en = 1'b0;

      rd_bad  = (pos_x == '0) || (pos_x > count_x);
      // one extra bit so that length + 1 cannot wrap on a full list
      ins_bad = (pos_x == '0) || ({1'b0, pos_x} > ({1'b0, count_x} + (XW+1)'(1)));

      unique case (state_ff)
         olst_pkg::ST_IDLE: begin
            if (accept) begin
               action_in   = olst_pkg::action_type'(req_action);
               position_in = req_position;
               key_in      = req_item_value;
               scan_in     = '0;
               state_in    = (olst_pkg::action_type'(req_action) == olst_pkg::ACT_INSERT)
                             ? olst_pkg::ST_FINISH : olst_pkg::ST_SCAN;
            end
         end
         olst_pkg::ST_SCAN: begin
            // let the search wave reach cell 0
            scan_in = scan_ff + SCW'(1);
            if (scan_ff == SCAN_LAST) begin
               state_in = olst_pkg::ST_FINISH;
            end
         end
         olst_pkg::ST_FINISH: begin
            state_in      = olst_pkg::ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_found_in  = '0;
            rsp_status_in = olst_pkg::STATUS_OK;
            unique case (action_ff)
               olst_pkg::ACT_GET: begin
                  if (rd_bad) begin
                     rsp_status_in = olst_pkg::STATUS_RANGE;
                  end else begin
                     rsp_value_in = carry_value[0];
                  end
               end
               olst_pkg::ACT_LOCATE: begin
                  rsp_found_in = olst_pkg::LEN_W'(carry_pos[0]);
               end
               olst_pkg::ACT_INSERT: begin
                  priority if (ins_bad) begin
                     rsp_status_in = olst_pkg::STATUS_RANGE;
                  end else if (count_ff == CAP_C) begin
                     rsp_status_in = olst_pkg::STATUS_FULL;
                  end else begin
                     ctl.insert_en = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end
               olst_pkg::ACT_DELETE: begin
                  if (rd_bad) begin
                     rsp_status_in = olst_pkg::STATUS_RANGE;
                  end else begin
                     rsp_value_in  = carry_value[0];
                     ctl.delete_en = 1'b1;
                     count_in      = count_ff - CW'(1);
                  end
               end
               default: begin
                  rsp_status_in = olst_pkg::STATUS_OK;
               end
            endcase
            rsp_length_in = olst_pkg::LEN_W'(count_in);
         end
         default: begin
            state_in = olst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      action_ff     <= action_in;
      position_ff   <= position_in;
      key_ff        <= key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [olst_pkg::VAL_W-1:0] left_value;
      logic [olst_pkg::VAL_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      olst_cell #(
         .INDEX (i),
         .CW    (CW),
         .XW    (XW)
      ) u_cell (
         .clock           (clock),
         .ctl             (ctl),
         .pos_x           (pos_x),
         .count_x         (count_x),
         .key             (key_ff),
         .left_value      (left_value),
         .right_value     (right_value),
         .carry_in_value  (carry_value[i+1]),
         .carry_in_pos    (carry_pos[i+1]),
         .value           (cell_value[i]),
         .carry_out_value (carry_value[i]),
         .carry_out_pos   (carry_pos[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_list_length    = rsp_length_ff;

endmodule
